@@ rtl/zde_pkg.sv @@
// zde_pkg: shared types, constants and the fibonacci weight table
// for the zeckendorf digit encoder; depends on nothing
package zde_pkg;

  localparam int NUM_FIBS = 43;
  localparam int VALUE_W  = 30;
  localparam int WEIGHT_W = 32;
  localparam int POS_W    = $clog2(NUM_FIBS);

  typedef logic [WEIGHT_W-1:0] weight_tbl_t [NUM_FIBS];

  // weights 1, 2, 3, 5, 8, ... built at elaboration
  function automatic weight_tbl_t build_weights();
    weight_tbl_t w;
    w[0] = WEIGHT_W'(1);
    w[1] = WEIGHT_W'(2);
    for (int k = 2; k < NUM_FIBS; k++) begin
      w[k] = w[k-1] + w[k-2];
    end
    return w;
  endfunction

  localparam weight_tbl_t WEIGHTS = build_weights();

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_RUN
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic find;
    logic emit_special;
    logic emit_digit;
  } zde_cmd_t;

  typedef struct packed {
    logic is_zero;
    logic is_big;
    logic pos_zero;
  } zde_status_t;

endpackage

@@ rtl/zde_ctrl.sv @@
// zde_ctrl: sequencing state machine and output valid flag
// depends on zde_pkg
module zde_ctrl import zde_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  zde_status_t status,
  output zde_cmd_t    cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       special;

  assign slot_free = !out_valid_r || out_ready;
  assign special   = status.is_zero || status.is_big;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_FIND;
      end
      ST_FIND: begin
        if (!special) state_nxt = ST_RUN;
        else if (slot_free) state_nxt = ST_IDLE;
      end
      ST_RUN: begin
        if (slot_free && status.pos_zero) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_FIND: begin
        cmd.find         = !special;
        cmd.emit_special = special && slot_free;
      end
      ST_RUN: begin
        cmd.emit_digit = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_special || cmd.emit_digit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/zde_datapath.sv @@
// zde_datapath: remainder and position registers, top search, output word register
// depends on zde_pkg
module zde_datapath import zde_pkg::*; (
  input  logic               clk,
  input  logic [VALUE_W-1:0] in_value,
  input  zde_cmd_t           cmd,
  output zde_status_t        status,
  output logic               out_digit,
  output logic               out_last,
  output logic               out_empty_res,
  output logic               out_too_large
);

  logic [VALUE_W-1:0]  rem_r, rem_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    top;
  logic [WEIGHT_W-1:0] rem_ext;
  logic [WEIGHT_W-1:0] cur_w;
  logic [WEIGHT_W-1:0] diff;
  logic                ge_cur;
  logic digit_r, last_r, empty_r, big_r;

  assign rem_ext = WEIGHT_W'(rem_r);
  assign cur_w   = WEIGHTS[pos_r];
  assign ge_cur  = rem_ext >= cur_w;
  assign diff    = rem_ext - cur_w;

  // highest weight not above the remainder
  always_comb begin
    top = '0;
    for (int k = 0; k < NUM_FIBS; k++) begin
      if (rem_ext >= WEIGHTS[k]) top = POS_W'(k);
    end
  end

  assign status.is_zero  = (rem_r == '0);
  assign status.is_big   = rem_ext >= WEIGHTS[NUM_FIBS-1];
  assign status.pos_zero = (pos_r == '0);

  always_comb begin
    rem_nxt = rem_r;
    pos_nxt = pos_r;
    if (cmd.load) begin
      rem_nxt = in_value;
    end else if (cmd.find) begin
      pos_nxt = top;
    end else if (cmd.emit_digit) begin
      if (ge_cur) rem_nxt = diff[VALUE_W-1:0];
      pos_nxt = pos_r - POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    pos_r <= pos_nxt;
    if (cmd.emit_special) begin
      digit_r <= 1'b0;
      last_r  <= 1'b1;
      empty_r <= status.is_zero;
      big_r   <= !status.is_zero;
    end else if (cmd.emit_digit) begin
      digit_r <= ge_cur;
      last_r  <= status.pos_zero;
      empty_r <= 1'b0;
      big_r   <= 1'b0;
    end
  end

  assign out_digit     = digit_r;
  assign out_last      = last_r;
  assign out_empty_res = empty_r;
  assign out_too_large = big_r;

endmodule

@@ rtl/zeckendorf_digit_encoder.sv @@
// zeckendorf_digit_encoder: top level, joins controller and datapath
// depends on zde_pkg, zde_ctrl, zde_datapath
//
//  channel | ports                                          | dir
//  in      | in_valid, in_ready, in_value[29:0]             | in
//  out     | out_valid, out_ready, out_digit, out_last,     | out
//          | out_empty_res, out_too_large                   |
//
// a word is loaded, then the top-position search runs, then output words follow
// one per cycle while the output is not stalled; for zero or too-large input
// the search cycle writes the single output word
// the digit loop walks the position register down through the weight table
// synchronous active-low reset clears the state machine and output valid
// a stalled output holds the digit loop; a new input is taken once the last
// output word of the run is in the output register
module zeckendorf_digit_encoder import zde_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_digit,
  output logic               out_last,
  output logic               out_empty_res,
  output logic               out_too_large
);

  zde_cmd_t    cmd;
  zde_status_t status;

  zde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  zde_datapath u_dp (
    .clk           (clk),
    .in_value      (in_value),
    .cmd           (cmd),
    .status        (status),
    .out_digit     (out_digit),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .out_too_large (out_too_large)
  );

endmodule
